### src/cswg_pkg.sv
package cswg_pkg;

  localparam int unsigned COEF_W     = 18;
  localparam int unsigned ROT_W      = 32;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned ACC_W      = 26;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned FRAC       = 30;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 4;

  localparam logic [SIZE_W-1:0] MAX_WINDOW = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ZERO,
    REG_COEF_ONE,
    REG_COEF_TWO,
    REG_COEF_THREE,
    REG_ROT_COS,
    REG_ROT_SIN,
    REG_WINDOW_SIZE
  } reg_idx_e;

  localparam logic signed [COEF_W-1:0] COEF_ZERO_RST  = 18'sd27525;
  localparam logic signed [COEF_W-1:0] COEF_ONE_RST   = 18'sd32768;
  localparam logic signed [COEF_W-1:0] COEF_TWO_RST   = 18'sd5243;
  localparam logic signed [COEF_W-1:0] COEF_THREE_RST = 18'sd0;
  localparam logic signed [ROT_W-1:0]  ROT_COS_RST    = 32'sd1073721572;
  localparam logic signed [ROT_W-1:0]  ROT_SIN_RST    = 32'sd6594796;
  localparam logic [SIZE_W-1:0]        SIZE_RST       = 17'd1024;

  localparam logic signed [ROT_W-1:0]  Q30_ONE   = 32'sh4000_0000;
  localparam logic signed [ROT_W-1:0]  Q30_MONE  = 32'shC000_0000;
  localparam logic signed [PROD_W-1:0] Q30_HALF  = 64'sd536870912;
  localparam logic signed [PROD_W-1:0] PH_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] PH_MIN    = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [ACC_W-1:0]  VAL_MAX   = 26'sd131071;
  localparam logic signed [ACC_W-1:0]  VAL_MIN   = -26'sd131072;

  typedef enum logic [1:0] {MA_K3, MA_ACC, MA_COS, MA_SIN} mul_a_e;
  typedef enum logic       {MB_RE, MB_IM} mul_b_e;
  typedef enum logic [1:0] {ACC_NONE, ACC_K2, ACC_K1, ACC_K0} acc_op_e;
  typedef enum logic [1:0] {SUM_NONE, SUM_LOAD, SUM_SUB, SUM_ADD} sum_op_e;
  typedef enum logic [1:0] {HOLD_NONE, HOLD_REQ, HOLD_RSP} hold_e;

  typedef struct packed {
    mul_a_e             mul_a;
    mul_b_e             mul_b;
    logic               mul_en;
    acc_op_e            acc_op;
    sum_op_e            sum_op;
    logic               emit;
    hold_e              hold;
    logic [STEP_W-1:0]  next;
  } ucw_t;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_K3   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_K2   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_T1   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_K1   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_T2   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_K0   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_IM   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd8;

  // Cubic chain on the multiplier interleaved with the phasor products.
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    case (step)
      STEP_IDLE: w = ucw_t'{MA_K3,  MB_RE, 1'b0, ACC_NONE, SUM_NONE, 1'b0, HOLD_REQ,  STEP_K3};
      STEP_K3:   w = ucw_t'{MA_K3,  MB_RE, 1'b1, ACC_NONE, SUM_NONE, 1'b0, HOLD_NONE, STEP_K2};
      STEP_K2:   w = ucw_t'{MA_COS, MB_RE, 1'b1, ACC_K2,   SUM_NONE, 1'b0, HOLD_NONE, STEP_T1};
      STEP_T1:   w = ucw_t'{MA_ACC, MB_RE, 1'b1, ACC_NONE, SUM_LOAD, 1'b0, HOLD_NONE, STEP_K1};
      STEP_K1:   w = ucw_t'{MA_SIN, MB_IM, 1'b1, ACC_K1,   SUM_NONE, 1'b0, HOLD_NONE, STEP_T2};
      STEP_T2:   w = ucw_t'{MA_ACC, MB_RE, 1'b1, ACC_NONE, SUM_SUB,  1'b0, HOLD_NONE, STEP_K0};
      STEP_K0:   w = ucw_t'{MA_COS, MB_IM, 1'b1, ACC_K0,   SUM_NONE, 1'b0, HOLD_NONE, STEP_IM};
      STEP_IM:   w = ucw_t'{MA_SIN, MB_RE, 1'b1, ACC_NONE, SUM_LOAD, 1'b0, HOLD_NONE, STEP_EMIT};
      STEP_EMIT: w = ucw_t'{MA_K3,  MB_RE, 1'b0, ACC_NONE, SUM_ADD,  1'b1, HOLD_RSP,  STEP_IDLE};
      default:   w = ucw_t'{MA_K3,  MB_RE, 1'b0, ACC_NONE, SUM_NONE, 1'b0, HOLD_NONE, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/cswg_if.sv
interface cswg_req_if;
  import cswg_pkg::*;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cswg_rsp_if;
  import cswg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] value;
  logic [IDX_W-1:0]         index_front;
  logic [IDX_W-1:0]         index_back;
  logic                     last;
  modport source (output valid, output value, output index_front, output index_back,
                  output last, input ready);
  modport sink   (input valid, input value, input index_front, input index_back,
                  input last, output ready);
endinterface

interface cswg_cfg_if;
  import cswg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/cosine_sum_window_generator_core.sv
// Channel | Dir | Payload                                    | Transfer
// cfg_i   | in  | index (register), data                     | valid && ready
// req_i   | in  | restart                                    | valid && ready
// rsp_o   | out | value, index_front, index_back, last       | valid && ready
//
// One sample is the request transfer, then eight steps of the microcode program,
// which share one 32x32 multiplier between the cubic and the phasor rotation.
// The result sits in an output register, so the next request is taken while it waits;
// the program holds on its final step only while that register is full and not taken.
// Reset loads the register defaults and parks the phasor at -1, index zero.
// Configuration is taken every cycle; rotation and size are clamped as they are written.
module cosine_sum_window_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  cswg_cfg_if.sink    cfg_i,
  cswg_req_if.sink    req_i,
  cswg_rsp_if.source  rsp_o
);
  import cswg_pkg::*;

  logic signed [COEF_W-1:0] coef0_q, coef1_q, coef2_q, coef3_q;
  logic signed [ROT_W-1:0]  rot_cos_q, rot_sin_q;
  logic [SIZE_W-1:0]        size_q;

  logic signed [ROT_W-1:0]  phase_re_q, phase_im_q, re_nx_q;
  logic [SIZE_W-1:0]        idx_q;
  logic [STEP_W-1:0]        step_q, step_d;

  logic signed [PROD_W-1:0] prod_q, sum_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic                     rsp_valid_q;
  logic signed [COEF_W-1:0] rsp_value_q;
  logic [IDX_W-1:0]         rsp_front_q, rsp_back_q;
  logic                     rsp_last_q;

  ucw_t                     uc;
  logic                     stall, adv, req_fire, new_run;
  logic signed [ROT_W-1:0]  cfg_rot;
  logic [SIZE_W-1:0]        cfg_size;
  logic [IDX_W-1:0]         half;

  logic signed [ACC_W-1:0]  a0_x, a1_x, a2_x, a3_x, k_sel, acc_rnd, sum4, v_src, v_sat;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_res, prod_rnd, sum_fin, sum_sh;
  logic signed [ROT_W-1:0]  ph_sat;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;
  assign cfg_rot = signed'(cfg_i.data);

  always_comb begin
    if (cfg_i.data[SIZE_W-1:0] == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (cfg_i.data[SIZE_W-1:0] > MAX_WINDOW) begin
      cfg_size = MAX_WINDOW;
    end else begin
      cfg_size = cfg_i.data[SIZE_W-1:0];
    end
  end

  function automatic logic signed [ROT_W-1:0] clamp_rot(input logic signed [ROT_W-1:0] v);
    if (v > Q30_ONE) begin
      return Q30_ONE;
    end else if (v < Q30_MONE) begin
      return Q30_MONE;
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef0_q   <= COEF_ZERO_RST;
      coef1_q   <= COEF_ONE_RST;
      coef2_q   <= COEF_TWO_RST;
      coef3_q   <= COEF_THREE_RST;
      rot_cos_q <= ROT_COS_RST;
      rot_sin_q <= ROT_SIN_RST;
      size_q    <= SIZE_RST;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_COEF_ZERO:   coef0_q   <= signed'(cfg_i.data[COEF_W-1:0]);
        REG_COEF_ONE:    coef1_q   <= signed'(cfg_i.data[COEF_W-1:0]);
        REG_COEF_TWO:    coef2_q   <= signed'(cfg_i.data[COEF_W-1:0]);
        REG_COEF_THREE:  coef3_q   <= signed'(cfg_i.data[COEF_W-1:0]);
        REG_ROT_COS:     rot_cos_q <= clamp_rot(cfg_rot);
        REG_ROT_SIN:     rot_sin_q <= clamp_rot(cfg_rot);
        REG_WINDOW_SIZE: size_q    <= cfg_size;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign uc       = ucode(step_q);
  assign req_fire = req_i.valid && req_i.ready;
  assign half     = size_q[SIZE_W-1:1];
  assign new_run  = req_i.restart || (idx_q > {1'b0, half});

  always_comb begin
    case (uc.hold)
      HOLD_REQ: stall = !req_i.valid;
      HOLD_RSP: stall = rsp_valid_q && !rsp_o.ready;
      default:  stall = 1'b0;
    endcase
  end

  assign adv         = !stall;
  assign step_d      = adv ? uc.next : step_q;
  assign req_i.ready = (step_q == STEP_IDLE);

  // ---------------------------------------------------------------- datapath
  assign a0_x = ACC_W'(coef0_q);
  assign a1_x = ACC_W'(coef1_q);
  assign a2_x = ACC_W'(coef2_q);
  assign a3_x = ACC_W'(coef3_q);

  always_comb begin
    case (uc.acc_op)
      ACC_K2:  k_sel = a2_x <<< 1;
      ACC_K1:  k_sel = a1_x - a3_x - (a3_x <<< 1);
      ACC_K0:  k_sel = a0_x - a2_x;
      default: k_sel = '0;
    endcase
  end

  always_comb begin
    case (uc.mul_a)
      MA_K3:   mul_a = MUL_W'(a3_x <<< 2);
      MA_ACC:  mul_a = MUL_W'(acc_q);
      MA_COS:  mul_a = rot_cos_q;
      MA_SIN:  mul_a = rot_sin_q;
      default: mul_a = '0;
    endcase
  end

  assign mul_b   = (uc.mul_b == MB_IM) ? phase_im_q : phase_re_q;
  assign mul_res = mul_a * mul_b;

  // Round the Q.46 product back to Q.16 (floor after adding half).
  assign prod_rnd = (prod_q + Q30_HALF) >>> FRAC;
  assign acc_rnd  = signed'(prod_rnd[ACC_W-1:0]);

  // sum_q already carries the rounding half from its load.
  assign sum_fin = (uc.sum_op == SUM_SUB) ? (sum_q - prod_q) : (sum_q + prod_q);
  assign sum_sh  = sum_fin >>> FRAC;

  always_comb begin
    if (sum_sh > PH_MAX) begin
      ph_sat = signed'(PH_MAX[ROT_W-1:0]);
    end else if (sum_sh < PH_MIN) begin
      ph_sat = signed'(PH_MIN[ROT_W-1:0]);
    end else begin
      ph_sat = signed'(sum_sh[ROT_W-1:0]);
    end
  end

  // Size one degenerates to the plain sum of the weights.
  assign sum4  = a0_x + a1_x + a2_x + a3_x;
  assign v_src = (size_q == SIZE_W'(1)) ? sum4 : acc_q;

  always_comb begin
    if (v_src > VAL_MAX) begin
      v_sat = VAL_MAX;
    end else if (v_src < VAL_MIN) begin
      v_sat = VAL_MIN;
    end else begin
      v_sat = v_src;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      rsp_valid_q <= 1'b0;
      phase_re_q  <= Q30_MONE;
      phase_im_q  <= '0;
      idx_q       <= '0;
    end else begin
      step_q <= step_d;
      if (req_fire && new_run) begin
        phase_re_q <= Q30_MONE;
        phase_im_q <= '0;
        idx_q      <= '0;
      end
      if (adv && uc.sum_op == SUM_ADD) begin
        phase_re_q <= re_nx_q;
        phase_im_q <= ph_sat;
        idx_q      <= idx_q + SIZE_W'(1);
      end
      if (adv && uc.emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && uc.mul_en) begin
      prod_q <= mul_res;
    end
    if (adv && uc.acc_op != ACC_NONE) begin
      acc_q <= k_sel + acc_rnd;
    end
    if (adv && uc.sum_op == SUM_LOAD) begin
      sum_q <= prod_q + Q30_HALF;
    end
    if (adv && uc.sum_op == SUM_SUB) begin
      re_nx_q <= ph_sat;
    end
    if (adv && uc.emit) begin
      rsp_value_q <= signed'(v_sat[COEF_W-1:0]);
      rsp_front_q <= idx_q[IDX_W-1:0];
      rsp_back_q  <= IDX_W'(size_q - idx_q - SIZE_W'(1));
      rsp_last_q  <= (idx_q == {1'b0, half});
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.value       = rsp_value_q;
  assign rsp_o.index_front = rsp_front_q;
  assign rsp_o.index_back  = rsp_back_q;
  assign rsp_o.last        = rsp_last_q;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_EMIT)
    else $error("sequencer left its program");

  a_start_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> step_q == STEP_K3)
    else $error("request transfer did not start the program");

  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (IDX_W'(rsp_o.index_front + rsp_o.index_back + IDX_W'(1))
                     == size_q[IDX_W-1:0]))
    else $error("mirrored index does not match window size");

  a_last_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.last) |-> rsp_o.index_front == half)
    else $error("last flagged away from the window centre");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cswg_pkg::*;

  localparam int     ITEMS          = 600;
  localparam int     IDLE_LIMIT     = 1000;
  localparam int     HOLD_OFF_LEN   = 80;
  localparam int     HOLD_OFF_AT    = 250;
  localparam int     DIRECTED_ROWS  = 31;
  localparam longint Q30            = 64'sd1073741824;
  localparam longint PHASE_MAX      = 64'sd2147483647;
  localparam longint PHASE_MIN      = -64'sd2147483648;
  localparam longint SAMPLE_MAX     = 64'sd131071;
  localparam longint SAMPLE_MIN     = -64'sd131072;

  typedef struct packed {
    logic signed [COEF_W-1:0] value;
    logic [IDX_W-1:0]         index_front;
    logic [IDX_W-1:0]         index_back;
    logic                     last;
  } sample_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_REQ_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    reg_idx_e   idx;
    logic [31:0] data;
    logic       restart;
    sample_t    want;
  } stim_row_t;

  localparam sample_t NO_SAMPLE = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cswg_cfg_if cfg_if ();
  cswg_req_if req_if ();
  cswg_rsp_if rsp_if ();

  cosine_sum_window_generator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Window generator state as the software sees it.
  logic [31:0]     reg_shadow [7];
  longint          phase_re;
  longint          phase_im;
  logic [SIZE_W-1:0] run_index;

  sample_t expected_samples [$];
  int      mismatches = 0;
  int      accepted_requests = 0;
  int      burst_left = 0;
  logic    hold_off_active = 1'b0;

  function automatic longint round_q30(input longint p);
    return (p + (Q30 >>> 1)) >>> 30;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic sample_t next_sample(input logic restart);
    sample_t s;
    longint  win, half, i, a0, a1, a2, a3, re, im, rc, rs, t, v;
    win = longint'(reg_shadow[REG_WINDOW_SIZE][SIZE_W-1:0]);
    if (win == 0) win = 1;
    if (win > longint'(MAX_WINDOW)) win = longint'(MAX_WINDOW);
    half = win >>> 1;
    if (restart || longint'(run_index) > half) begin
      phase_re  = -Q30;
      phase_im  = 0;
      run_index = '0;
    end
    i  = longint'(run_index);
    a0 = longint'($signed(reg_shadow[REG_COEF_ZERO][COEF_W-1:0]));
    a1 = longint'($signed(reg_shadow[REG_COEF_ONE][COEF_W-1:0]));
    a2 = longint'($signed(reg_shadow[REG_COEF_TWO][COEF_W-1:0]));
    a3 = longint'($signed(reg_shadow[REG_COEF_THREE][COEF_W-1:0]));
    re = phase_re;
    im = phase_im;
    if (win == 1) begin
      v = a0 + a1 + a2 + a3;
    end else begin
      // Horner form of the folded cubic in the phasor's real part
      t = 4 * a3;
      t = 2 * a2 + round_q30(t * re);
      t = (a1 - 3 * a3) + round_q30(t * re);
      v = (a0 - a2) + round_q30(t * re);
    end
    v  = clamp(v, SAMPLE_MIN, SAMPLE_MAX);
    rc = clamp(longint'($signed(reg_shadow[REG_ROT_COS])), -Q30, Q30);
    rs = clamp(longint'($signed(reg_shadow[REG_ROT_SIN])), -Q30, Q30);
    phase_re  = clamp(round_q30(rc * re - rs * im), PHASE_MIN, PHASE_MAX);
    phase_im  = clamp(round_q30(rc * im + rs * re), PHASE_MIN, PHASE_MAX);
    run_index = SIZE_W'(i + 1);
    s.value       = COEF_W'(v);
    s.index_front = IDX_W'(i);
    s.index_back  = IDX_W'(win - i - 1);
    s.last        = (i == half);
    return s;
  endfunction

  function automatic logic [31:0] coef_word(input int kind, input int k);
    logic [COEF_W-1:0] c;
    case (kind)
      0: begin
        c = (k < 2) ? 18'd32768 : 18'd0;
      end
      1: begin
        case (k)
          0:       c = 18'd27525;
          1:       c = 18'd32768;
          2:       c = 18'd5243;
          default: c = 18'd0;
        endcase
      end
      2: begin
        case (k)
          0:       c = 18'd23511;
          1:       c = 18'd32001;
          2:       c = 18'd9259;
          default: c = 18'd765;
        endcase
      end
      3: begin
        c = COEF_W'($urandom);
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       c = 18'h1FFFF;
          1:       c = 18'h20000;
          default: c = 18'h00000;
        endcase
      end
    endcase
    return {14'($urandom), c};
  endfunction

  function automatic logic [31:0] rot_word(input longint win, input logic want_sin);
    real ang;
    if (win > 1 && $urandom_range(0, 3) != 0) begin
      ang = 6.283185307179586 / real'(win - 1);
      return want_sin ? 32'($rtoi($sin(ang) * 1073741824.0))
                      : 32'($rtoi($cos(ang) * 1073741824.0));
    end
    if ($urandom_range(0, 1) == 0) return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h4000_0000;
      1:       return 32'hC000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic write_register(input reg_idx_e idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    reg_shadow[idx] = data;
    @(negedge clk_i);
  endtask

  task automatic offer_request(input logic restart, input logic typed, input sample_t want);
    sample_t predicted;
    int      gap;
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = next_sample(restart);
    expected_samples.push_back(typed ? want : predicted);
    accepted_requests++;
    @(negedge clk_i);
    // Bursts of back-to-back requests with idle gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) < 3 || hold_off_active) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain_samples();
    req_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
  endtask

  stim_row_t directed_rows [DIRECTED_ROWS];

  initial begin
    logic             cfg_open;
    logic [SIZE_W-1:0] win_size;
    longint           eff;
    int               kind;
    int               n;
    int               pick;

    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    req_if.valid   = 1'b0;
    req_if.restart = 1'b0;

    reg_shadow[REG_COEF_ZERO]   = 32'(COEF_ZERO_RST);
    reg_shadow[REG_COEF_ONE]    = 32'(COEF_ONE_RST);
    reg_shadow[REG_COEF_TWO]    = 32'(COEF_TWO_RST);
    reg_shadow[REG_COEF_THREE]  = 32'(COEF_THREE_RST);
    reg_shadow[REG_ROT_COS]     = 32'(ROT_COS_RST);
    reg_shadow[REG_ROT_SIN]     = 32'(ROT_SIN_RST);
    reg_shadow[REG_WINDOW_SIZE] = 32'(SIZE_RST);
    phase_re  = -Q30;
    phase_im  = 0;
    run_index = '0;

    directed_rows = '{
      // reset defaults: first sample of the reset window sits at zero
      '{ROW_REQ_TYPED, REG_COEF_ZERO,   32'h0000_0000, 1'b0, '{18'sd0, 16'd0, 16'd1023, 1'b0}},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ_TYPED, REG_COEF_ZERO,   32'h0000_0000, 1'b1, '{18'sd0, 16'd0, 16'd1023, 1'b0}},
      // all weights at the top, size one: the sum saturates high
      '{ROW_CFG,       REG_COEF_ZERO,   32'h0001_FFFF, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_COEF_ONE,    32'hFFFD_FFFF, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_COEF_TWO,    32'h0001_FFFF, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_COEF_THREE,  32'h0001_FFFF, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_WINDOW_SIZE, 32'h0000_0001, 1'b0, NO_SAMPLE},
      '{ROW_REQ_TYPED, REG_COEF_ZERO,   32'h0000_0000, 1'b0, '{18'sd131071, 16'd0, 16'd0, 1'b1}},
      '{ROW_REQ_TYPED, REG_COEF_ZERO,   32'h0000_0000, 1'b0, '{18'sd131071, 16'd0, 16'd0, 1'b1}},
      // all weights at the bottom, size zero taken as one
      '{ROW_CFG,       REG_COEF_ZERO,   32'hFFFE_0000, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_COEF_ONE,    32'hFFFE_0000, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_COEF_TWO,    32'hFFFE_0000, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_COEF_THREE,  32'hFFFE_0000, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_WINDOW_SIZE, 32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ_TYPED, REG_COEF_ZERO,   32'h0000_0000, 1'b1, '{-18'sd131072, 16'd0, 16'd0, 1'b1}},
      // oversize window, out-of-range rotation: phasor runs into saturation
      '{ROW_CFG,       REG_WINDOW_SIZE, 32'h0001_FFFF, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_ROT_COS,     32'h7FFF_FFFF, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_ROT_SIN,     32'h8000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ_TYPED, REG_COEF_ZERO,   32'h0000_0000, 1'b1, '{18'sd0, 16'd0, 16'hFFFF, 1'b0}},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      // size dropped below the running index: a fresh window follows
      '{ROW_CFG,       REG_ROT_COS,     32'h4000_0000, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_ROT_SIN,     32'hC000_0000, 1'b0, NO_SAMPLE},
      '{ROW_CFG,       REG_WINDOW_SIZE, 32'h0000_0004, 1'b0, NO_SAMPLE},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE},
      '{ROW_REQ,       REG_COEF_ZERO,   32'h0000_0000, 1'b0, NO_SAMPLE}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cfg_open = 1'b0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        if (!cfg_open) drain_samples();
        cfg_open = 1'b1;
        write_register(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        if (cfg_open) cfg_if.valid <= 1'b0;
        cfg_open = 1'b0;
        offer_request(directed_rows[r].restart, directed_rows[r].kind == ROW_REQ_TYPED,
                      directed_rows[r].want);
      end
    end

    while (accepted_requests < ITEMS) begin
      drain_samples();
      pick = $urandom_range(0, 99);
      if (pick < 70)      win_size = SIZE_W'($urandom_range(1, 40));
      else if (pick < 88) win_size = SIZE_W'($urandom_range(41, 400));
      else if (pick < 95) win_size = SIZE_W'($urandom_range(401, 65536));
      else if (pick < 97) win_size = '0;
      else                win_size = SIZE_W'($urandom_range(65536, 131071));
      if ($urandom_range(0, 3) == 0) begin
        // shrink the window only, leaving the run where it stands
        win_size = SIZE_W'($urandom_range(1, 12));
        write_register(REG_WINDOW_SIZE, {15'($urandom), win_size});
      end else begin
        eff = longint'(win_size);
        if (eff == 0) eff = 1;
        if (eff > longint'(MAX_WINDOW)) eff = longint'(MAX_WINDOW);
        kind = $urandom_range(0, 4);
        write_register(REG_COEF_ZERO,   coef_word(kind, 0));
        write_register(REG_COEF_ONE,    coef_word(kind, 1));
        write_register(REG_COEF_TWO,    coef_word(kind, 2));
        write_register(REG_COEF_THREE,  coef_word(kind, 3));
        write_register(REG_ROT_COS,     rot_word(eff, 1'b0));
        write_register(REG_ROT_SIN,     rot_word(eff, 1'b1));
        write_register(REG_WINDOW_SIZE, {15'($urandom), win_size});
      end
      cfg_if.valid <= 1'b0;
      n = $urandom_range(8, 60);
      // keep offering through the long hold-off so the input backs up
      while (n > 0 || hold_off_active ||
             (accepted_requests >= HOLD_OFF_AT && accepted_requests < HOLD_OFF_AT + 8)) begin
        offer_request($urandom_range(0, 99) < 8, 1'b0, NO_SAMPLE);
        n--;
      end
    end

    drain_samples();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Response side: stall pattern of its own, plus one long hold-off
  initial begin
    int   mode;
    int   mode_left;
    int   tick;
    int   hold_left;
    logic hold_done;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_off_active = 1'b0;
        rsp_if.ready <= (hold_left == 0);
      end else if (!hold_done && accepted_requests >= HOLD_OFF_AT) begin
        hold_done       = 1'b1;
        hold_left       = HOLD_OFF_LEN;
        hold_off_active = 1'b1;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= $urandom_range(0, 1);
          2:       rsp_if.ready <= (tick % 4 == 0);
          default: rsp_if.ready <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    sample_t want;
    sample_t got;
    if (rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.value, rsp_if.index_front, rsp_if.index_back, rsp_if.last};
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: value %0d index_front %0d",
               $signed(got.value), got.index_front);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (got.value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
          mismatches++;
        end
        if (got.index_front !== want.index_front) begin
          $error("index_front: expected %0d, got %0d", want.index_front, got.index_front);
          mismatches++;
        end
        if (got.index_back !== want.index_back) begin
          $error("index_back: expected %0d, got %0d", want.index_back, got.index_back);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // Give up once no transfer has happened on any channel for too long
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
